FILE: design/sor_tess_pkg.sv
// Shared types, constants and trig table functions for the surface tessellator.
`timescale 1ns / 1ps

package sor_tess_pkg;

   // Field widths
   localparam int COORD_W   = 16;
   localparam int IDX_W     = 10;
   localparam int CFG_W     = 7;
   localparam int CNT_W     = 6;
   localparam int COEF_W    = 16;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int REQ_DATA_W = 3 * COORD_W;
   localparam int RSP_DATA_W = IDX_W + 3 * COORD_W + 3 * IDX_W;

   // Defaults for the top-level parameters
   localparam int STEPS_DEF       = 16;
   localparam int MAX_PROFILE_DEF = 64;
   localparam int PROFILE_RESET   = 2;
   localparam int MIN_PROFILE     = 2;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Result kinds
   localparam logic KIND_VERTEX   = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

   // Fixed-point constants for the table evaluation
   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // One profile point handed from front to back
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic        [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic        [CNT_W-1:0]   point_idx;
      logic        [CFG_W-1:0]   plen;
      logic                      has_tri;
   } cmd_type;

   // Queue status seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_VERT,
      ST_TRI
   } seq_state_type;

   function automatic longint mul30(input longint a, input longint b);
      return (a * b) >>> 30;
   endfunction

   // Clamp at zero and round Q2.30 to Q1.14
   function automatic longint to_q14(input longint v);
      longint w;
      w = (v < 0) ? 64'sd0 : v;
      return (w + 64'sd32768) >>> 16;
   endfunction

   // First-quadrant sine, Horner to x^9
   function automatic longint sin_core(input longint u);
      longint x;
      longint x2;
      longint t;
      x  = (u * HALF_PI_Q30) >>> 16;
      x2 = mul30(x, x);
      t  = Q30_ONE - mul30(x2, Q30_ONE) / 72;
      t  = Q30_ONE - mul30(x2, t) / 42;
      t  = Q30_ONE - mul30(x2, t) / 20;
      t  = Q30_ONE - mul30(x2, t) / 6;
      return to_q14(mul30(x, t));
   endfunction

   // First-quadrant cosine, Horner to x^10
   function automatic longint cos_core(input longint u);
      longint x;
      longint x2;
      longint t;
      x  = (u * HALF_PI_Q30) >>> 16;
      x2 = mul30(x, x);
      t  = Q30_ONE - mul30(x2, Q30_ONE) / 90;
      t  = Q30_ONE - mul30(x2, t) / 56;
      t  = Q30_ONE - mul30(x2, t) / 30;
      t  = Q30_ONE - mul30(x2, t) / 12;
      t  = Q30_ONE - mul30(x2, t) / 2;
      return to_q14(t);
   endfunction

   // Cosine for phase u within quadrant q, Q1.14
   function automatic logic signed [COEF_W-1:0] trig_cos(input longint u, input int q);
      longint c;
      longint s;
      longint r;
      c = cos_core(u);
      s = sin_core(u);
      case (q & 3)
         0:       r = c;
         1:       r = -s;
         2:       r = -c;
         default: r = s;
      endcase
      return COEF_W'(r);
   endfunction

   // Sine for phase u within quadrant q, Q1.14
   function automatic logic signed [COEF_W-1:0] trig_sin(input longint u, input int q);
      longint c;
      longint s;
      longint r;
      c = cos_core(u);
      s = sin_core(u);
      case (q & 3)
         0:       r = s;
         1:       r = c;
         2:       r = -s;
         default: r = -c;
      endcase
      return COEF_W'(r);
   endfunction

endpackage

FILE: design/surface_of_revolution_tessellator.sv
// Top level of the surface-of-revolution tessellator.
`timescale 1ns / 1ps

// Revolves a profile about the y axis. Each word on the req_ channel is one
// profile point (x, y, z in signed Q8.8). Point i of the profile yields STEPS
// vertex words (index i + j*P, j ascending) and, from the second point on,
// two triangle words per step joining the rings of points i-1 and i. rsp_tuser
// marks a triangle word, rsp_tlast marks the final word of a point.
// The profile length P is written on csr_wdata with csr_we; a write also
// restarts the surface at point 0. Write it only while the block is idle.
// The first word of a point passes through the command queue, the command
// register, the product stage and the output register.
// Throughput: one result word per cycle while rsp_tready is high, set by the
// single rotation datapath and output register: STEPS words for a first point,
// 3*STEPS words for the others (48 at STEPS = 16). Points are taken while
// earlier ones are still being expanded; a two-entry command queue holds them.
// Reset sets P to 2, the point counter to 0 and empties queue and pipeline.
// When rsp_tready is low the output word holds and the pipeline stalls; once
// the queue fills, req_tready drops.
module surface_of_revolution_tessellator #(
   parameter int STEPS       = sor_tess_pkg::STEPS_DEF,
   parameter int MAX_PROFILE = sor_tess_pkg::MAX_PROFILE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // point_x [15:0], point_y [31:16], point_z [47:32]
   input  logic [sor_tess_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // vertex_index [9:0], vert_x [25:10], vert_y [41:26], vert_z [57:42],
   // corner_a [67:58], corner_b [77:68], corner_c [87:78]
   output logic [sor_tess_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [sor_tess_pkg::CFG_W-1:0]      csr_wdata
);

   sor_tess_pkg::queue_status_type q_status;
   sor_tess_pkg::cmd_type          push_cmd;
   sor_tess_pkg::cmd_type          head_cmd;
   logic                           q_push;
   logic                           q_pop;

   sor_tess_front #(
      .MAX_PROFILE(MAX_PROFILE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   sor_tess_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   sor_tess_back #(
      .STEPS(STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: design/sor_tess_front.sv
// Front end: accepts profile points, tracks the point counter, builds commands.
`timescale 1ns / 1ps

module sor_tess_front #(
   parameter int MAX_PROFILE = sor_tess_pkg::MAX_PROFILE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sor_tess_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                                  csr_we,
   input  logic [sor_tess_pkg::CFG_W-1:0]        csr_wdata,
   input  sor_tess_pkg::queue_status_type        q_status,
   output logic                                  q_push,
   output sor_tess_pkg::cmd_type                 q_cmd
);

   localparam int CFG_W = sor_tess_pkg::CFG_W;
   localparam int CNT_W = sor_tess_pkg::CNT_W;
   localparam int CW    = sor_tess_pkg::COORD_W;

   logic [CFG_W-1:0] profile_ff;
   logic [CFG_W-1:0] profile_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CFG_W-1:0] plen;
   logic [CFG_W-1:0] idx_wide;
   logic [CFG_W-1:0] next_wide;
   logic             accept;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && !q_status.full;

   // Clamp the profile length to the supported range
   always_comb begin
      if (profile_ff < CFG_W'(sor_tess_pkg::MIN_PROFILE)) begin
         plen = CFG_W'(sor_tess_pkg::MIN_PROFILE);
      end else if (profile_ff > CFG_W'(MAX_PROFILE)) begin
         plen = CFG_W'(MAX_PROFILE);
      end else begin
         plen = profile_ff;
      end
   end

   // Restart the profile when the counter is at or past the length
   assign idx_wide  = ({1'b0, count_ff} >= plen) ? '0 : {1'b0, count_ff};
   assign next_wide = idx_wide + CFG_W'(1);

   // Build the command for the back end
   always_comb begin
      q_push          = accept;
      q_cmd.x         = req_tdata[CW-1:0];
      q_cmd.y         = req_tdata[2*CW-1:CW];
      q_cmd.z         = req_tdata[3*CW-1:2*CW];
      q_cmd.point_idx = idx_wide[CNT_W-1:0];
      q_cmd.plen      = plen;
      q_cmd.has_tri   = (idx_wide != '0);
   end

   // Update length register and point counter
   always_comb begin
      profile_in = profile_ff;
      count_in   = count_ff;
      if (csr_we) begin
         profile_in = csr_wdata;
         count_in   = '0;
      end else if (accept) begin
         count_in = (next_wide >= plen) ? '0 : next_wide[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ff <= CFG_W'(sor_tess_pkg::PROFILE_RESET);
         count_ff   <= '0;
      end else begin
         profile_ff <= profile_in;
         count_ff   <= count_in;
      end
   end

endmodule

FILE: design/sor_tess_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module sor_tess_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  sor_tess_pkg::cmd_type          push_cmd,
   input  logic                           pop,
   output sor_tess_pkg::cmd_type          head_cmd,
   output sor_tess_pkg::queue_status_type status
);

   localparam int DEPTH = sor_tess_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sor_tess_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (fill_ff == CNT_W'(DEPTH));
   assign status.empty = (fill_ff == '0);
   assign head_cmd     = mem_ff[rd_ptr_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: design/sor_tess_back.sv
// Back end: steps through the rings of one point and emits vertices and triangles.
`timescale 1ns / 1ps

module sor_tess_back #(
   parameter int STEPS = sor_tess_pkg::STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sor_tess_pkg::cmd_type                 head_cmd,
   input  sor_tess_pkg::queue_status_type        q_status,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sor_tess_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int CW     = sor_tess_pkg::COORD_W;
   localparam int IW     = sor_tess_pkg::IDX_W;
   localparam int KW     = sor_tess_pkg::COEF_W;
   localparam int PW     = sor_tess_pkg::PROD_W;
   localparam int SW     = PW + 2;
   localparam int JW     = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [JW-1:0] J_LAST = JW'(STEPS - 1);

   // Rotation table, folded at elaboration
   logic signed [KW-1:0] cos_tab [STEPS];
   logic signed [KW-1:0] sin_tab [STEPS];

   for (genvar g = 0; g < STEPS; g++) begin : g_tab
      localparam int     Q = (4 * g) / STEPS;
      localparam int     R = (4 * g) % STEPS;
      localparam longint U = (longint'(R) * 65536 + STEPS / 2) / STEPS;
      assign cos_tab[g] = sor_tess_pkg::trig_cos(U, Q);
      assign sin_tab[g] = sor_tess_pkg::trig_sin(U, Q);
   end

   // Sequencer state
   sor_tess_pkg::seq_state_type state_ff;
   sor_tess_pkg::seq_state_type state_in;
   sor_tess_pkg::cmd_type       cmd_ff;
   sor_tess_pkg::cmd_type       cmd_in;
   logic [JW-1:0] j_ff;
   logic [JW-1:0] j_in;
   logic          half_ff;
   logic          half_in;
   logic [IW-1:0] jp_ff;
   logic [IW-1:0] jp_in;

   // Pipeline: product stage and output word
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s1_kind_ff;
   logic                 s1_last_ff;
   logic [IW-1:0]        s1_vidx_ff;
   logic [CW-1:0]        s1_y_ff;
   logic signed [PW-1:0] s1_xc_ff;
   logic signed [PW-1:0] s1_zs_ff;
   logic signed [PW-1:0] s1_zc_ff;
   logic signed [PW-1:0] s1_xs_ff;
   logic [IW-1:0]        s1_ca_ff;
   logic [IW-1:0]        s1_cb_ff;
   logic [IW-1:0]        s1_cc_ff;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic                 out_kind_ff;
   logic                 out_last_ff;
   logic [IW-1:0]        out_vidx_ff;
   logic [CW-1:0]        out_x_ff;
   logic [CW-1:0]        out_y_ff;
   logic [CW-1:0]        out_z_ff;
   logic [IW-1:0]        out_ca_ff;
   logic [IW-1:0]        out_cb_ff;
   logic [IW-1:0]        out_cc_ff;

   logic          busy;
   logic          s2_load;
   logic          s1_load;
   logic          issue;
   logic          load_req;
   logic          op_last;
   logic [IW-1:0] plen_w;
   logic [IW-1:0] idx_w;
   logic [IW-1:0] prev_w;
   logic [IW-1:0] np_w;
   logic [IW-1:0] op_ca;
   logic [IW-1:0] op_cb;
   logic [IW-1:0] op_cc;
   logic signed [SW-1:0] sum_x;
   logic signed [SW-1:0] sum_z;
   logic [CW-1:0] sat_x;
   logic [CW-1:0] sat_z;

   // Round a Q9.22 sum to Q8.8, ties up, and saturate
   function automatic logic [CW-1:0] round_sat(input logic signed [SW-1:0] s);
      logic signed [SW-1:0] r;
      r = (s + SW'(8192)) >>> 14;
      if (r > SW'(32767)) begin
         return CW'(32767);
      end else if (r < -SW'(32768)) begin
         return CW'(-32768);
      end else begin
         return r[CW-1:0];
      end
   endfunction

   // Stall handling: each stage loads when the next one frees up
   assign s2_load = !out_valid_ff || rsp_tready;
   assign s1_load = !s1_valid_ff || s2_load;
   assign busy    = (state_ff != sor_tess_pkg::ST_IDLE);
   assign issue   = busy && s1_load;

   // Ring index arithmetic for the current step
   assign plen_w = IW'(cmd_ff.plen);
   assign idx_w  = IW'(cmd_ff.point_idx);
   assign prev_w = idx_w - IW'(1);
   assign np_w   = (j_ff == J_LAST) ? '0 : jp_ff + plen_w;

   always_comb begin
      if (!half_ff) begin
         op_ca = prev_w + np_w;
         op_cb = idx_w + np_w;
         op_cc = idx_w + jp_ff;
      end else begin
         op_ca = idx_w + jp_ff;
         op_cb = prev_w + jp_ff;
         op_cc = prev_w + np_w;
      end
   end

   assign op_last = (j_ff == J_LAST)
                    && ((state_ff == sor_tess_pkg::ST_VERT) ? !cmd_ff.has_tri : half_ff);

   // Next state of the sequencer
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      j_in     = j_ff;
      half_in  = half_ff;
      jp_in    = jp_ff;
      load_req = 1'b0;
      q_pop    = 1'b0;
      case (state_ff)
         sor_tess_pkg::ST_IDLE: begin
            load_req = 1'b1;
         end
         sor_tess_pkg::ST_VERT: begin
            if (issue) begin
               if (j_ff == J_LAST) begin
                  if (cmd_ff.has_tri) begin
                     state_in = sor_tess_pkg::ST_TRI;
                     j_in     = '0;
                     jp_in    = '0;
                     half_in  = 1'b0;
                  end else begin
                     load_req = 1'b1;
                  end
               end else begin
                  j_in  = j_ff + JW'(1);
                  jp_in = jp_ff + plen_w;
               end
            end
         end
         sor_tess_pkg::ST_TRI: begin
            if (issue) begin
               if (!half_ff) begin
                  half_in = 1'b1;
               end else if (j_ff == J_LAST) begin
                  load_req = 1'b1;
               end else begin
                  j_in    = j_ff + JW'(1);
                  jp_in   = jp_ff + plen_w;
                  half_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = sor_tess_pkg::ST_IDLE;
         end
      endcase
      // Pick up the next point without a gap
      if (load_req) begin
         if (!q_status.empty) begin
            q_pop    = 1'b1;
            cmd_in   = head_cmd;
            state_in = sor_tess_pkg::ST_VERT;
            j_in     = '0;
            jp_in    = '0;
            half_in  = 1'b0;
         end else begin
            state_in = sor_tess_pkg::ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sor_tess_pkg::ST_IDLE;
         j_ff     <= '0;
         half_ff  <= 1'b0;
         jp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         half_ff  <= half_in;
         jp_ff    <= jp_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   // Valid bits of the two stages
   assign s1_valid_in  = s1_load ? issue : s1_valid_ff;
   assign out_valid_in = s2_load ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Product stage: four rotation products or triangle corners
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_last_ff <= op_last;
         s1_xc_ff   <= cmd_ff.x * cos_tab[j_ff];
         s1_zs_ff   <= cmd_ff.z * sin_tab[j_ff];
         s1_zc_ff   <= cmd_ff.z * cos_tab[j_ff];
         s1_xs_ff   <= cmd_ff.x * sin_tab[j_ff];
         if (state_ff == sor_tess_pkg::ST_VERT) begin
            s1_kind_ff <= sor_tess_pkg::KIND_VERTEX;
            s1_vidx_ff <= idx_w + jp_ff;
            s1_y_ff    <= cmd_ff.y;
            s1_ca_ff   <= '0;
            s1_cb_ff   <= '0;
            s1_cc_ff   <= '0;
         end else begin
            s1_kind_ff <= sor_tess_pkg::KIND_TRIANGLE;
            s1_vidx_ff <= '0;
            s1_y_ff    <= '0;
            s1_ca_ff   <= op_ca;
            s1_cb_ff   <= op_cb;
            s1_cc_ff   <= op_cc;
         end
      end
   end

   // Sum, round and saturate the rotated coordinates
   assign sum_x = SW'(s1_xc_ff) + SW'(s1_zs_ff);
   assign sum_z = SW'(s1_zc_ff) - SW'(s1_xs_ff);
   assign sat_x = round_sat(sum_x);
   assign sat_z = round_sat(sum_z);

   // Output word
   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         out_kind_ff <= s1_kind_ff;
         out_last_ff <= s1_last_ff;
         out_vidx_ff <= s1_vidx_ff;
         out_y_ff    <= s1_y_ff;
         out_ca_ff   <= s1_ca_ff;
         out_cb_ff   <= s1_cb_ff;
         out_cc_ff   <= s1_cc_ff;
         if (s1_kind_ff == sor_tess_pkg::KIND_VERTEX) begin
            out_x_ff <= sat_x;
            out_z_ff <= sat_z;
         end else begin
            out_x_ff <= '0;
            out_z_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {out_cc_ff, out_cb_ff, out_ca_ff,
                        out_z_ff, out_y_ff, out_x_ff, out_vidx_ff};

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the surface-of-revolution tessellator.
`timescale 1ns / 1ps

module tb_top;

   localparam int RING_STEPS    = sor_tess_pkg::STEPS_DEF;
   localparam int PROFILE_MAX   = sor_tess_pkg::MAX_PROFILE_DEF;
   localparam int IDX_W         = sor_tess_pkg::IDX_W;
   localparam int COORD_W       = sor_tess_pkg::COORD_W;
   localparam int CFG_W         = sor_tess_pkg::CFG_W;
   localparam int CNT_W         = sor_tess_pkg::CNT_W;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PCT      = 36;
   localparam int SETTLE_CYCLES = 10;

   // One expected result word
   typedef struct {
      logic               kind;
      logic [IDX_W-1:0]   vidx;
      logic [COORD_W-1:0] vx;
      logic [COORD_W-1:0] vy;
      logic [COORD_W-1:0] vz;
      logic [IDX_W-1:0]   ca;
      logic [IDX_W-1:0]   cb;
      logic [IDX_W-1:0]   cc;
      logic               last;
   } mesh_word_type;

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [sor_tess_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [sor_tess_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                                rsp_tuser;
   logic                                rsp_tlast;
   logic                                csr_we     = 1'b0;
   logic [CFG_W-1:0]                    csr_wdata  = '0;

   // Expected words, oldest first
   mesh_word_type mesh_words[$];

   // Rotation table in Q1.14
   longint cos_q14[RING_STEPS];
   longint sin_q14[RING_STEPS];

   // Shadow of the block's profile length and point counter
   logic [CFG_W-1:0] model_plen  = CFG_W'(sor_tess_pkg::PROFILE_RESET);
   logic [CNT_W-1:0] model_point = '0;

   int mismatches  = 0;
   int cycles      = 0;
   bit steady      = 1'b0;
   int hold_cycles = 0;

   surface_of_revolution_tessellator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   // Q2.30 product of two non-negative values
   function automatic longint q30_mul(input longint a, input longint b);
      return (a * b) >>> 30;
   endfunction

   // Clamp at zero, round Q2.30 down to Q1.14
   function automatic longint q30_to_q14(input longint v);
      if (v < 0)
         v = 0;
      return (v + 64'sd32768) >>> 16;
   endfunction

   // Round a Q9.22 sum to Q8.8, ties up, and saturate
   function automatic logic [COORD_W-1:0] sat_q88(input longint acc);
      longint v;
      v = (acc + 64'sd8192) >>> 14;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return COORD_W'(v);
   endfunction

   // Build the cos/sin table: Horner series on the first quadrant, then fold
   initial begin : rotation_table
      int     k;
      int     quad;
      int     rem;
      longint u;
      longint ang;
      longint ang2;
      longint acc;
      longint s1;
      longint c1;
      for (k = 0; k < RING_STEPS; k++) begin
         quad = (4 * k) / RING_STEPS;
         rem  = (4 * k) % RING_STEPS;
         u    = (longint'(rem) * 65536 + RING_STEPS / 2) / RING_STEPS;
         ang  = (u * sor_tess_pkg::HALF_PI_Q30) >>> 16;
         ang2 = q30_mul(ang, ang);
         acc  = sor_tess_pkg::Q30_ONE - q30_mul(ang2, sor_tess_pkg::Q30_ONE) / 72;
         acc  = sor_tess_pkg::Q30_ONE - q30_mul(ang2, acc) / 42;
         acc  = sor_tess_pkg::Q30_ONE - q30_mul(ang2, acc) / 20;
         acc  = sor_tess_pkg::Q30_ONE - q30_mul(ang2, acc) / 6;
         s1   = q30_to_q14(q30_mul(ang, acc));
         acc  = sor_tess_pkg::Q30_ONE - q30_mul(ang2, sor_tess_pkg::Q30_ONE) / 90;
         acc  = sor_tess_pkg::Q30_ONE - q30_mul(ang2, acc) / 56;
         acc  = sor_tess_pkg::Q30_ONE - q30_mul(ang2, acc) / 30;
         acc  = sor_tess_pkg::Q30_ONE - q30_mul(ang2, acc) / 12;
         acc  = sor_tess_pkg::Q30_ONE - q30_mul(ang2, acc) / 2;
         c1   = q30_to_q14(acc);
         case (quad & 3)
            0: begin
               cos_q14[k] = c1;
               sin_q14[k] = s1;
            end
            1: begin
               cos_q14[k] = -s1;
               sin_q14[k] = c1;
            end
            2: begin
               cos_q14[k] = -c1;
               sin_q14[k] = -s1;
            end
            default: begin
               cos_q14[k] = s1;
               sin_q14[k] = -c1;
            end
         endcase
      end
   end

   // Expand one accepted profile point into its vertex and triangle words
   function automatic void revolve_point(input logic [COORD_W-1:0] px,
                                         input logic [COORD_W-1:0] py,
                                         input logic [COORD_W-1:0] pz);
      longint        plen;
      longint        pi_idx;
      longint        xs;
      longint        zs;
      longint        nxt;
      longint        cur;
      int            j;
      bit            has_tri;
      mesh_word_type w;
      plen = model_plen;
      if (plen < sor_tess_pkg::MIN_PROFILE)
         plen = sor_tess_pkg::MIN_PROFILE;
      if (plen > PROFILE_MAX)
         plen = PROFILE_MAX;
      pi_idx = model_point;
      if (pi_idx >= plen)
         pi_idx = 0;
      has_tri = (pi_idx >= 1);
      xs = $signed(px);
      zs = $signed(pz);
      for (j = 0; j < RING_STEPS; j++) begin
         w = '{sor_tess_pkg::KIND_VERTEX, IDX_W'(pi_idx + j * plen),
               sat_q88(xs * cos_q14[j] + zs * sin_q14[j]), py,
               sat_q88(zs * cos_q14[j] - xs * sin_q14[j]),
               10'd0, 10'd0, 10'd0, !has_tri && (j == RING_STEPS - 1)};
         mesh_words.insert(mesh_words.size(), w);
      end
      if (has_tri) begin
         for (j = 0; j < RING_STEPS; j++) begin
            nxt = ((j + 1) % RING_STEPS) * plen;
            cur = j * plen;
            w = '{sor_tess_pkg::KIND_TRIANGLE, 10'd0, 16'd0, 16'd0, 16'd0,
                  IDX_W'(pi_idx - 1 + nxt), IDX_W'(pi_idx + nxt),
                  IDX_W'(pi_idx + cur), 1'b0};
            mesh_words.insert(mesh_words.size(), w);
            w = '{sor_tess_pkg::KIND_TRIANGLE, 10'd0, 16'd0, 16'd0, 16'd0,
                  IDX_W'(pi_idx + cur), IDX_W'(pi_idx - 1 + cur),
                  IDX_W'(pi_idx - 1 + nxt), j == RING_STEPS - 1};
            mesh_words.insert(mesh_words.size(), w);
         end
      end
      model_point = (pi_idx + 1 >= plen) ? '0 : CNT_W'(pi_idx + 1);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Compare each accepted word against the oldest expectation
   always @(posedge clock) begin : word_checker
      mesh_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mesh_words.size() == 0) begin
            $error("unexpected result word with no prediction pending");
            mismatches++;
         end else begin
            want = mesh_words.pop_front();
            check_field("kind", want.kind, rsp_tuser);
            check_field("vertex_index", want.vidx, rsp_tdata[9:0]);
            check_field("vert_x", want.vx, rsp_tdata[25:10]);
            check_field("vert_y", want.vy, rsp_tdata[41:26]);
            check_field("vert_z", want.vz, rsp_tdata[57:42]);
            check_field("corner_a", want.ca, rsp_tdata[67:58]);
            check_field("corner_b", want.cb, rsp_tdata[77:68]);
            check_field("corner_c", want.cc, rsp_tdata[87:78]);
            check_field("last_result", want.last, rsp_tlast);
         end
      end
   end

   // Drive the result-side ready; honor a requested hold-off first
   initial begin : rsp_sink
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offer one point, with random idle cycles ahead of it unless steady is set, and predict on accept
   task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                             input logic [COORD_W-1:0] pz);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pz, py, px};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      revolve_point(px, py, pz);
   endtask

   // Drop valid and wait for every expected word plus a settling margin
   task automatic wait_mesh_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mesh_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_profile(input logic [CFG_W-1:0] value);
      wait_mesh_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      model_plen  = value;
      model_point = '0;
      csr_we <= 1'b0;
   endtask

   // Mix of full-range, small, extreme and near-zero coordinates
   function automatic logic [COORD_W-1:0] draw_coord();
      case ($urandom_range(9))
         5, 6, 7: return COORD_W'($urandom_range(2048) - 1024);
         8:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         9:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   task automatic send_random_points(input int count);
      repeat (count) send_point(draw_coord(), draw_coord(), draw_coord());
   endtask

   // Reset length of two: first point vertices only, wrap, saturation
   task automatic test_default_profile();
      send_point(16'h0000, 16'h0000, 16'h0000);
      send_point(16'h7FFF, 16'h8000, 16'h7FFF);
      send_point(16'h8000, 16'h7FFF, 16'h8000);
      send_point(16'h8000, 16'h0000, 16'h7FFF);
      send_point(16'h0100, 16'hFF00, 16'h0080);
   endtask

   // Length clamps at both ends, a write mid-profile, odd length wrap
   task automatic test_profile_limits();
      write_profile(7'd0);
      send_point(16'h7FFF, 16'h7FFF, 16'h8000);
      send_point(16'hFFFF, 16'h0001, 16'hFFFF);
      write_profile(7'd1);
      send_point(16'h8000, 16'hFFFF, 16'h0000);
      write_profile(7'd127);
      send_random_points(3);
      write_profile(7'd64);
      send_random_points(2);
      write_profile(7'd3);
      send_random_points(4);
   endtask

   // One complete maximum-length profile reaches the top vertex index
   task automatic test_long_profile();
      write_profile(7'd64);
      send_random_points(64);
   endtask

   // Both sides without idle cycles
   task automatic test_streaming();
      write_profile(CFG_W'($urandom_range(8, 2)));
      steady = 1'b1;
      send_random_points(8);
      wait_mesh_drained();
      steady = 1'b0;
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      write_profile(7'd5);
      steady      = 1'b1;
      hold_cycles = 300;
      send_random_points(8);
      wait_mesh_drained();
      steady = 1'b0;
   endtask

   // Short surfaces of random length, complete or cut off by a rewrite
   task automatic test_random_profiles();
      int sent;
      int plen;
      int count;
      sent = 0;
      while (sent < 8) begin
         case ($urandom_range(9))
            9:       plen = $urandom_range(127, 65);
            8:       plen = $urandom_range(20, 10);
            default: plen = $urandom_range(9, 2);
         endcase
         count = $urandom_range((plen > 9) ? 9 : 2 * plen, 1);
         write_profile(CFG_W'(plen));
         send_random_points(count);
         sent += count;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_profile();
      test_profile_limits();
      test_long_profile();
      test_streaming();
      test_backpressure();
      test_random_profiles();
      wait_mesh_drained();
      if (mismatches == 0 && mesh_words.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: surface_of_revolution_tessellator.f
design/sor_tess_pkg.sv
design/sor_tess_front.sv
design/sor_tess_queue.sv
design/sor_tess_back.sv
design/surface_of_revolution_tessellator.sv
tb/sv/tb_top.sv
